>>> sv/pdq_pkg.sv
package pdq_pkg;

    // Ring geometry
    localparam int unsigned DEPTH  = 64;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W  = ADDR_W + 1;

    // Field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned PT_W    = 2 * COORD_W;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned OCNT_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic srch_step;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/pdq_ram.sv
module pdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pdq_dp.sv
module pdq_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdq_pkg::t_ctrl_cmd            i_cmd_bus,
    output pdq_pkg::t_dp_stat             o_stat,
    input  logic [pdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [pdq_pkg::PT_W-1:0]      i_point,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pdq_pkg::ST_W-1:0]      o_status,
    output logic [pdq_pkg::PT_W-1:0]      o_point,
    output logic                          o_found,
    output logic [pdq_pkg::OCNT_W-1:0]    o_count
);

    localparam logic [pdq_pkg::SUM_W-1:0]  DEPTH_S = pdq_pkg::SUM_W'(pdq_pkg::DEPTH);
    localparam logic [pdq_pkg::CNT_W-1:0]  DEPTH_C = pdq_pkg::CNT_W'(pdq_pkg::DEPTH);
    localparam logic [pdq_pkg::ADDR_W-1:0] LAST_A  = pdq_pkg::ADDR_W'(pdq_pkg::DEPTH - 1);

    // Ring position of head plus an offset below DEPTH
    function automatic logic [pdq_pkg::ADDR_W-1:0] ring_add(
        input logic [pdq_pkg::ADDR_W-1:0] head,
        input logic [pdq_pkg::SUM_W-1:0]  off
    );
        logic [pdq_pkg::SUM_W-1:0] sum;
        sum = pdq_pkg::SUM_W'(head) + off;
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[pdq_pkg::ADDR_W-1:0];
    endfunction

    logic [pdq_pkg::ADDR_W-1:0] r_head, n_head;
    logic [pdq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pdq_pkg::CNT_W-1:0]  r_k;
    logic                       r_cmp_v;
    logic                       r_found;
    logic                       r_pop_v;
    logic [pdq_pkg::ST_W-1:0]   r_st;
    logic [pdq_pkg::PT_W-1:0]   r_pt;

    logic                       r_out_valid;
    logic [pdq_pkg::ST_W-1:0]   r_out_st;
    logic [pdq_pkg::PT_W-1:0]   r_out_pt;
    logic                       r_out_found;
    logic [pdq_pkg::OCNT_W-1:0] r_out_cnt;

    logic                       ram_we, ram_re;
    logic [pdq_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [pdq_pkg::PT_W-1:0]   ram_rdata;
    logic                       is_full, is_empty, scan_more;
    logic [pdq_pkg::ADDR_W-1:0] head_m1;
    logic [pdq_pkg::ST_W-1:0]   n_st;
    logic                       n_pop_v;

    assign is_full   = (r_count == DEPTH_C);
    assign is_empty  = (r_count == '0);
    assign scan_more = (r_k < r_count);
    assign head_m1   = (r_head == '0) ? LAST_A : r_head - 1'b1;

    // Command decode at accept, and scan reads while searching
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_st      = pdq_pkg::ST_OK;
        n_pop_v   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_head;
        ram_raddr = r_head;
        if (i_cmd_bus.accept) begin
            case (i_cmd)
                pdq_pkg::CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_st = pdq_pkg::ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_add(r_head, pdq_pkg::SUM_W'(r_count));
                        n_count   = r_count + 1'b1;
                    end
                end
                pdq_pkg::CMD_PUSH_FRONT: begin
                    if (is_full) begin
                        n_st = pdq_pkg::ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = head_m1;
                        n_head    = head_m1;
                        n_count   = r_count + 1'b1;
                    end
                end
                pdq_pkg::CMD_POP_FRONT: begin
                    if (is_empty) begin
                        n_st = pdq_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_head;
                        n_head    = ring_add(r_head, pdq_pkg::SUM_W'(1));
                        n_count   = r_count - 1'b1;
                        n_pop_v   = 1'b1;
                    end
                end
                pdq_pkg::CMD_POP_BACK: begin
                    if (is_empty) begin
                        n_st = pdq_pkg::ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ring_add(r_head, pdq_pkg::SUM_W'(r_count - 1'b1));
                        n_count   = r_count - 1'b1;
                        n_pop_v   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd_bus.srch_step && scan_more) begin
            ram_re    = 1'b1;
            ram_raddr = ring_add(r_head, pdq_pkg::SUM_W'(r_k));
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_cmp_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd_bus.accept) begin
                r_cmp_v <= 1'b0;
            end else if (i_cmd_bus.srch_step) begin
                r_cmp_v <= scan_more;
            end
            if (i_cmd_bus.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload, scan index and result holding
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.accept) begin
            r_pt    <= i_point;
            r_st    <= n_st;
            r_pop_v <= n_pop_v;
            r_k     <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd_bus.srch_step && scan_more) begin
                r_k <= r_k + 1'b1;
            end
            if (r_cmp_v && (ram_rdata == r_pt)) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd_bus.load_out) begin
            r_out_st    <= r_st;
            r_out_pt    <= r_pop_v ? ram_rdata : '0;
            r_out_found <= r_found;
            r_out_cnt   <= pdq_pkg::OCNT_W'(r_count);
        end
    end

    pdq_ram #(
        .WIDTH (pdq_pkg::PT_W),
        .DEPTH (pdq_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_point),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_stat.scan_done = !scan_more && !r_cmp_v;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_point     = r_out_pt;
    assign o_found     = r_out_found;
    assign o_count     = r_out_cnt;

endmodule

>>> sv/pdq_ctrl.sv
module pdq_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [pdq_pkg::CMD_W-1:0] i_cmd,
    output logic                      o_ready,
    input  pdq_pkg::t_dp_stat         i_stat,
    output pdq_pkg::t_ctrl_cmd        o_cmd_bus
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_valid && (r_state == S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_cmd == pdq_pkg::CMD_SEARCH) ? S_SRCH : S_RESP;
                end
            end
            S_SRCH: begin
                if (i_stat.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready             = (r_state == S_IDLE);
    assign o_cmd_bus.accept    = accept;
    assign o_cmd_bus.srch_step = (r_state == S_SRCH);
    assign o_cmd_bus.load_out  = (r_state == S_RESP) && i_stat.out_free;

endmodule

>>> sv/point_deque_with_search_core.sv
// Push, pop and unused commands go from idle to the response state, which registers the result
// once the output register is free; only then is a new request taken. Search first scans the
// live entries through the single read port of the point store, one live entry per cycle.
// The output register lets a new request in while a result waits to be taken.
// Reset (i_rst_n, synchronous, active low) empties the ring and clears the output
// valid; the point store itself is not cleared.
module point_deque_with_search_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x[15:0], point_y[31:16]
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_x[15:0], out_y[31:16], count[38:32], zero[39]
    output logic [2:0]  m_axis_tuser    // status[1:0], found[2]
);

    pdq_pkg::t_ctrl_cmd               cmd_bus;
    pdq_pkg::t_dp_stat                stat;
    logic [pdq_pkg::ST_W-1:0]         status;
    logic [pdq_pkg::PT_W-1:0]         point;
    logic                             found;
    logic [pdq_pkg::OCNT_W-1:0]       count;

    pdq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_cmd     (s_axis_tuser),
        .o_ready   (s_axis_tready),
        .i_stat    (stat),
        .o_cmd_bus (cmd_bus)
    );

    pdq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_bus   (cmd_bus),
        .o_stat      (stat),
        .i_cmd       (s_axis_tuser),
        .i_point     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (status),
        .o_point     (point),
        .o_found     (found),
        .o_count     (count)
    );

    assign m_axis_tdata = {1'b0, count, point};
    assign m_axis_tuser = {found, status};

endmodule

>>> verif/point_deque_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the point deque, predicts each reply from its own
// copy of the ring and compares the replies as they are taken.
module point_deque_checker
    import pdq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,    // point_x[15:0], point_y[31:16]
    input  logic [2:0]  i_req_cmd,     // cmd[2:0]
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [39:0] i_rsp_data,    // out_x[15:0], out_y[31:16], count[38:32], zero[39]
    input  logic [2:0]  i_rsp_user,    // status[1:0], found[2]
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               found;
        logic [OCNT_W-1:0]  count;
    } t_deque_reply;

    // Shadow ring
    logic [PT_W-1:0] point_ring [DEPTH];
    int unsigned     ring_head = 0;
    int unsigned     ring_live = 0;

    t_deque_reply replies_due [$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;
    initial o_pending = 0;

    // Apply one request to the shadow ring and return the reply it must give
    function automatic t_deque_reply deque_outcome(input logic [CMD_W-1:0] cmd,
                                                   input logic [PT_W-1:0]  pt);
        t_deque_reply    r;
        logic [PT_W-1:0] popped;
        int unsigned     slot;
        r      = '0;
        popped = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH_BACK: begin
                if (ring_live >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (ring_head + ring_live) % DEPTH;
                    point_ring[slot] = pt;
                    ring_live++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (ring_live >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_head = (ring_head == 0) ? DEPTH - 1 : ring_head - 1;
                    point_ring[ring_head] = pt;
                    ring_live++;
                end
            end
            CMD_POP_FRONT: begin
                if (ring_live == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    popped    = point_ring[ring_head];
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_live--;
                end
            end
            CMD_POP_BACK: begin
                if (ring_live == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    popped = point_ring[(ring_head + ring_live - 1) % DEPTH];
                    ring_live--;
                end
            end
            CMD_SEARCH: begin
                // live entries only, full 32-bit match
                for (int unsigned k = 0; k < ring_live; k++) begin
                    if (point_ring[(ring_head + k) % DEPTH] == pt) begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.out_x = popped[COORD_W-1:0];
        r.out_y = popped[PT_W-1:COORD_W];
        r.count = ring_live[OCNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Replies are matched before the request of the same edge is predicted
    always @(posedge i_clk) begin
        t_deque_reply want;
        if (!i_rst_n) begin
            ring_head = 0;
            ring_live = 0;
            replies_due.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (replies_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected reply: expected none, actual %h/%h",
                             $time, i_rsp_user, i_rsp_data);
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, i_rsp_user[1:0]);
                    check_field("found", want.found, i_rsp_user[2]);
                    check_field("out_x", want.out_x, i_rsp_data[15:0]);
                    check_field("out_y", want.out_y, i_rsp_data[31:16]);
                    check_field("count", want.count, i_rsp_data[38:32]);
                    check_field("pad", 1'b0, i_rsp_data[39]);
                end
            end
            if (i_req_valid && i_req_ready) begin
                replies_due.push_back(deque_outcome(i_req_cmd, i_req_data));
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pdq_pkg::*;

    localparam int          STALL_LIMIT   = 5000;
    localparam int          RANDOM_ITEMS  = 1400;
    localparam int          HOLD_AT       = 60;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TAIL_CYCLES   = 80;
    localparam logic [2:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_SEARCH} t_phase;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data  = '0;
    logic [2:0]  s_cmd   = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;
    logic [2:0]  m_user;

    int fail_count;
    int pending;
    int n_accepted  = 0;
    int idle_cycles = 0;

    // Sender pacing and point history
    int          burst_left = 0;
    bit          tight      = 1'b0;
    int          n_random   = 0;
    logic [31:0] pushed_hist [32];
    int          hist_fill  = 0;
    int          hist_wr    = 0;
    logic [15:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    point_deque_with_search_core u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_cmd),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    point_deque_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (s_valid),
        .i_req_ready  (s_ready),
        .i_req_data   (s_data),
        .i_req_cmd    (s_cmd),
        .i_rsp_valid  (m_valid),
        .i_rsp_ready  (m_ready),
        .i_rsp_data   (m_data),
        .i_rsp_user   (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Accepted requests and idle cycles
    always @(posedge clk) begin
        if (rst_n && s_valid && s_ready) begin
            n_accepted <= n_accepted + 1;
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        do @(posedge clk); while (idle_cycles < STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: stall pattern of its own, one long hold-off while the sender fills the ring
    initial begin
        int  mode;
        int  len;
        bit  held;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 60);
            if (!held && n_accepted >= HOLD_AT) begin
                held = 1'b1;
                mode = 4;
                len  = HOLD_CYCLES;
            end
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= (i % 3 == 0);
                    3:       m_ready <= ($urandom_range(0, 7) == 0);
                    default: m_ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    // Offer one request and wait for it to be taken
    task automatic offer_request(input logic [2:0] cmd, input logic [31:0] pt);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (tight) begin
                gap = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(13, 70);
            end else begin
                gap = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_data  <= pt;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        if (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) begin
            pushed_hist[hist_wr] = pt;
            hist_wr = (hist_wr + 1) % 32;
            if (hist_fill < 32) hist_fill++;
        end
    endtask

    // Hold the input idle until every reply has been taken
    task automatic drain_wait();
        s_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        burst_left = 0;
    endtask

    // Point for a push: random, corner coordinates or a small pool with repeats
    function automatic logic [31:0] fresh_point();
        int r;
        int k;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, 7);
        if (r < 5) return $urandom;
        if (r < 7) return {corners[$urandom_range(0, 3)], corners[$urandom_range(0, 3)]};
        return {16'(k * 3), 16'(k)};
    endfunction

    // Point for a search: recent pushes, near misses of them, or fresh
    function automatic logic [31:0] probe_point();
        int r;
        r = $urandom_range(0, 9);
        if (hist_fill > 0 && r < 5) return pushed_hist[$urandom_range(0, hist_fill - 1)];
        if (hist_fill > 0 && r < 7) begin
            return pushed_hist[$urandom_range(0, hist_fill - 1)] ^ (32'h1 << $urandom_range(0, 31));
        end
        return fresh_point();
    endfunction

    function automatic logic [2:0] pick_cmd(input t_phase kind);
        int r;
        int push_top;
        int pop_top;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL:  begin push_top = 73; pop_top = 88; end
            PH_DRAIN: begin push_top = 18; pop_top = 83; end
            PH_MIX:   begin push_top = 43; pop_top = 83; end
            default:  begin push_top = 33; pop_top = 53; end
        endcase
        if (r < 3) return 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        if (r < push_top) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (r < pop_top) return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        return CMD_SEARCH;
    endfunction

    task automatic run_phase(input t_phase kind, input int len);
        logic [2:0] c;
        for (int i = 0; i < len; i++) begin
            c = pick_cmd(kind);
            offer_request(c, (c == CMD_SEARCH) ? probe_point() : fresh_point());
            n_random++;
        end
    endtask

    // Stimulus and verdict
    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops and search, corners, wrap of the head, stale search
        // data is {y, x}
        offer_request(CMD_POP_FRONT,  32'h0);
        offer_request(CMD_POP_BACK,   32'h0);
        offer_request(CMD_SEARCH,     32'h0);
        offer_request(CMD_UNUSED_LO,  32'hFFFF_FFFF);
        offer_request(CMD_PUSH_BACK,  {16'h8000, 16'h7FFF});
        offer_request(CMD_PUSH_FRONT, {16'h7FFF, 16'h8000});
        offer_request(CMD_PUSH_BACK,  {16'hFFFF, 16'hFFFF});
        offer_request(CMD_PUSH_FRONT, {16'h0000, 16'h0000});
        offer_request(CMD_SEARCH,     {16'h8000, 16'h7FFF});
        offer_request(CMD_SEARCH,     {16'h7FFF, 16'h7FFF});
        offer_request(CMD_SEARCH,     {16'h8000, 16'h8000});
        offer_request(CMD_POP_BACK,   32'h0);
        offer_request(CMD_SEARCH,     {16'hFFFF, 16'hFFFF});
        offer_request(CMD_POP_FRONT,  32'h0);
        offer_request(CMD_UNUSED_LO + 3'd1, 32'h1234_5678);
        offer_request(CMD_UNUSED_HI,  32'h8000_8000);
        offer_request(CMD_POP_FRONT,  32'h0);
        offer_request(CMD_POP_BACK,   32'h0);
        offer_request(CMD_POP_BACK,   32'h0);
        offer_request(CMD_SEARCH,     {16'h7FFF, 16'h8000});
        drain_wait();

        // Fill past full with no gaps; the receiver holds off meanwhile
        tight = 1'b1;
        run_phase(PH_FILL, 160);
        tight = 1'b0;
        drain_wait();
        run_phase(PH_DRAIN, 90);

        while (n_random < RANDOM_ITEMS) begin
            tight = ($urandom_range(0, 4) == 0);
            run_phase(t_phase'($urandom_range(0, 3)), $urandom_range(30, 150));
            if ($urandom_range(0, 2) == 0) drain_wait();
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
